// File: rtl/admee_pkg.sv
// Shared types and constants of the adaptive diagonal mass estimator.
`default_nettype none
package admee_pkg;
    localparam int NUM_ELEMENTS = 1024;
    localparam int IDX_W = 10;
    localparam int DATA_W = 32;
    localparam int MV_W = 2 * DATA_W;
    localparam int DIV_NUM_W = 65;
    localparam int DIV_DEN_W = 48;
    localparam int DIV_CNT_W = 7;
    localparam int SQRT_W = 49;
    localparam int PADDR_W = 3;
    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
    localparam logic [7:0] DEFAULT_WEIGHT = 8'd5;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_PRIOR = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic REG_FREEZE = 1'b0;
    localparam logic REG_WEIGHT = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE, S_CLEAR, S_READ, S_Q1, S_Q1W, S_C, S_SQ, S_T2, S_T2W, S_VN,
        S_T1, S_T1W, S_BL, S_BLG, S_BLW, S_INV, S_INVW, S_SQW, S_EMIT
    } t_state;
endpackage
`default_nettype wire

// File: rtl/admee_if.sv
// Valid/ready channel interfaces for input items and result items.
`default_nettype none
interface admee_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic [9:0]         element_index;
    logic signed [31:0] value;
    logic               last_element;
    modport source (output valid, opcode, element_index, value, last_element, input ready);
    modport sink (input valid, opcode, element_index, value, last_element, output ready);
endinterface

interface admee_out_if;
    logic        valid;
    logic        ready;
    logic [9:0]  result_index;
    logic [31:0] mass;
    logic [31:0] inv_sqrt_mass;
    modport source (output valid, result_index, mass, inv_sqrt_mass, input ready);
    modport sink (input valid, result_index, mass, inv_sqrt_mass, output ready);
endinterface
`default_nettype wire

// File: rtl/adaptive_diagonal_mass_estimator_unit.sv
// Top level of the adaptive diagonal mass estimator: control, memories and APB registers.
//
//   Channel   Direction  Transfer on               Carries
//   i_in      in         i_in.valid & i_in.ready   opcode, element_index, value, last_element
//   o_out     out        o_out.valid & o_out.ready result_index, mass, inv_sqrt_mass
//   APB       in/out     psel & penable & pwrite   freeze (0x0), prior_weight (0x4)
//
// One item is worked on at a time. An add with a nonzero count makes five passes through
// the shared 65-step divider and then a square root; a first-vector add or a prior write
// skips the mean and variance steps, a zero mass skips the inverse root, and a clear
// runs the zeroing pass below.
// After reset and after every clear, a pass zeroes the mean/variance memory one entry
// per cycle while i_in.ready stays low; register writes are taken as ever.
// A finished result sits in the output register, so a new item is accepted while it waits;
// only a result that finds the previous one still untaken stalls until that transfer.
`default_nettype none
module adaptive_diagonal_mass_estimator_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    admee_in_if.sink                             i_in,
    admee_out_if.source                          o_out,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [admee_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready
);
    admee_pkg::t_state r_state, n_state;

    // Item registers and intermediate results of the update sequence.
    logic [1:0]   r_op, n_op;
    logic [9:0]   r_idx, n_idx;
    logic [31:0]  r_x, n_x;
    logic         r_last, n_last;
    logic [31:0]  r_mean, n_mean, r_var, n_var, r_prior, n_prior, r_mnew, n_mnew;
    logic         r_neg, n_neg;
    logic [31:0]  r_c, n_c, r_mass, n_mass, r_inv, n_inv;
    logic [64:0]  r_prod, n_prod, r_t2, n_t2;
    logic [9:0]   r_clr, n_clr;
    logic [31:0]  r_count, n_count;
    logic [7:0]   r_pw, n_pw;
    logic         r_freeze, n_freeze;
    logic         r_ovalid, n_ovalid;
    logic [9:0]   r_oidx, n_oidx;
    logic [31:0]  r_omass, n_omass, r_oinv, n_oinv;

    // Memory and arithmetic unit hookup.
    logic         mv_we, pr_we;
    logic [9:0]   mv_waddr, rd_addr;
    logic [63:0]  mv_wdata, mv_rdata;
    logic [31:0]  pr_rdata;
    logic         div_start, div_busy, div_done, sq_start, sq_done;
    logic [64:0]  div_num, div_quot;
    logic [47:0]  div_den;
    logic [48:0]  sq_root;

    // Combinational helpers.
    logic         in_acc, cfg_wr, idx_ok;
    logic [32:0]  cnt1, diff, mag, bden, pclamp;
    logic [31:0]  bm;
    logic [40:0]  bprod;
    logic [65:0]  vsum;
    logic [63:0]  sq_prod, vn_prod;

    admee_ram #(.WIDTH(admee_pkg::MV_W), .DEPTH(admee_pkg::NUM_ELEMENTS)) u_mv_ram (
        .i_clk(i_clk), .i_we(mv_we), .i_waddr(mv_waddr), .i_wdata(mv_wdata),
        .i_raddr(rd_addr), .o_rdata(mv_rdata)
    );

    admee_ram #(.WIDTH(admee_pkg::DATA_W), .DEPTH(admee_pkg::NUM_ELEMENTS)) u_pr_ram (
        .i_clk(i_clk), .i_we(pr_we), .i_waddr(i_in.element_index), .i_wdata(i_in.value),
        .i_raddr(rd_addr), .o_rdata(pr_rdata)
    );

    admee_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start), .i_num(div_num),
        .i_den(div_den), .o_busy(div_busy), .o_done(div_done), .o_quot(div_quot)
    );

    admee_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(sq_start), .i_val(div_quot[48:0]),
        .o_done(sq_done), .o_root(sq_root)
    );

    assign i_in.ready = (r_state == admee_pkg::S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign idx_ok     = 32'(i_in.element_index) < 32'(admee_pkg::NUM_ELEMENTS);
    assign rd_addr    = (r_state == admee_pkg::S_IDLE) ? i_in.element_index : r_idx;
    assign cnt1       = {1'b0, r_count} + 33'd1;
    assign pready     = 1'b1;
    assign cfg_wr     = psel && penable && pwrite;
    assign prdata     = (paddr[2] == admee_pkg::REG_WEIGHT) ? {24'd0, r_pw} : {31'd0, r_freeze};

    // Full-width products for the squared deviation and the scaled variance.
    assign sq_prod    = r_c * r_c;
    assign vn_prod    = r_var * r_count;

    assign o_out.valid         = r_ovalid;
    assign o_out.result_index  = r_oidx;
    assign o_out.mass          = r_omass;
    assign o_out.inv_sqrt_mass = r_oinv;

    // The blend weight m is the old count for a prior write and the saturated
    // incremented count for an add.
    always_comb begin
        if (r_op == admee_pkg::OP_PRIOR) begin
            bm = r_count;
        end else begin
            bm = (r_count == admee_pkg::COUNT_MAX) ? admee_pkg::COUNT_MAX : cnt1[31:0];
        end
        bden = 33'(bm) + 33'(r_pw);
    end

    always_comb begin
        n_state = r_state;  n_op = r_op;  n_idx = r_idx;  n_x = r_x;  n_last = r_last;
        n_mean = r_mean;  n_var = r_var;  n_prior = r_prior;  n_mnew = r_mnew;
        n_neg = r_neg;  n_c = r_c;  n_mass = r_mass;  n_inv = r_inv;  n_prod = r_prod;
        n_t2 = r_t2;  n_clr = r_clr;  n_count = r_count;  n_pw = r_pw;
        n_freeze = r_freeze;  n_ovalid = r_ovalid;  n_oidx = r_oidx;
        n_omass = r_omass;  n_oinv = r_oinv;
        mv_we = 1'b0;  mv_waddr = r_idx;  mv_wdata = '0;  pr_we = 1'b0;
        div_start = 1'b0;  div_num = '0;  div_den = '0;  sq_start = 1'b0;
        diff = '0;  mag = '0;  pclamp = '0;  bprod = '0;  vsum = '0;

        if (o_out.ready) begin
            n_ovalid = 1'b0;
        end

        if (cfg_wr) begin
            if (paddr[2] == admee_pkg::REG_FREEZE) begin
                n_freeze = pwdata[0];
            end else begin
                n_pw = pwdata[7:0];
            end
        end

        case (r_state)
            admee_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_op = i_in.opcode;  n_idx = i_in.element_index;
                    n_x = i_in.value;  n_last = i_in.last_element;
                    if (i_in.opcode == admee_pkg::OP_CLEAR) begin
                        n_count = '0;
                        n_pw    = admee_pkg::DEFAULT_WEIGHT;
                        n_clr   = '0;
                        n_state = admee_pkg::S_CLEAR;
                    end else if (i_in.opcode == admee_pkg::OP_PRIOR && idx_ok) begin
                        pr_we   = 1'b1;
                        n_pw    = admee_pkg::DEFAULT_WEIGHT;
                        n_state = admee_pkg::S_READ;
                    end else if (i_in.opcode == admee_pkg::OP_ADD && idx_ok && !r_freeze) begin
                        n_state = admee_pkg::S_READ;
                    end
                end
            end
            admee_pkg::S_CLEAR: begin
                mv_we    = 1'b1;
                mv_waddr = r_clr;
                n_clr    = r_clr + 1'b1;
                if (r_clr == 10'(admee_pkg::NUM_ELEMENTS - 1)) begin
                    n_state = admee_pkg::S_IDLE;
                end
            end
            admee_pkg::S_READ: begin
                n_mean  = mv_rdata[63:32];
                n_var   = mv_rdata[31:0];
                n_prior = (r_op == admee_pkg::OP_PRIOR) ? r_x : pr_rdata;
                if (r_op == admee_pkg::OP_PRIOR) begin
                    n_state = admee_pkg::S_BL;
                end else if (r_count == '0) begin
                    // First sample vector: the mean takes the sample, variance stays.
                    n_mnew   = r_x;
                    mv_we    = 1'b1;
                    mv_wdata = {r_x, mv_rdata[31:0]};
                    n_state  = admee_pkg::S_BL;
                end else begin
                    n_state = admee_pkg::S_Q1;
                end
            end
            admee_pkg::S_Q1: begin
                diff      = {r_x[31], r_x} - {r_mean[31], r_mean};
                mag       = diff[32] ? (~diff + 33'd1) : diff;
                n_neg     = diff[32];
                div_num   = 65'(mag) + 65'(cnt1 >> 1);
                div_den   = 48'(cnt1);
                div_start = 1'b1;
                n_state   = admee_pkg::S_Q1W;
            end
            admee_pkg::S_Q1W: begin
                if (div_done) begin
                    n_mnew  = r_neg ? (r_mean - div_quot[31:0]) : (r_mean + div_quot[31:0]);
                    n_state = admee_pkg::S_C;
                end
            end
            admee_pkg::S_C: begin
                diff    = {r_x[31], r_x} - {r_mnew[31], r_mnew};
                mag     = diff[32] ? (~diff + 33'd1) : diff;
                n_c     = mag[31:0];
                n_state = admee_pkg::S_SQ;
            end
            admee_pkg::S_SQ: begin
                n_prod  = {1'b0, sq_prod};
                n_state = admee_pkg::S_T2;
            end
            admee_pkg::S_T2: begin
                // The rounding offset is added in 64 bits and wraps there.
                div_num   = {1'b0, r_prod[63:0] + {17'd0, r_count, 15'd0}};
                div_den   = {r_count, 16'd0};
                div_start = 1'b1;
                n_state   = admee_pkg::S_T2W;
            end
            admee_pkg::S_T2W: begin
                if (div_done) begin
                    n_t2    = div_quot;
                    n_state = admee_pkg::S_VN;
                end
            end
            admee_pkg::S_VN: begin
                n_prod  = {1'b0, vn_prod};
                n_state = admee_pkg::S_T1;
            end
            admee_pkg::S_T1: begin
                div_num   = r_prod + 65'(cnt1 >> 1);
                div_den   = 48'(cnt1);
                div_start = 1'b1;
                n_state   = admee_pkg::S_T1W;
            end
            admee_pkg::S_T1W: begin
                if (div_done) begin
                    vsum     = 66'(div_quot) + 66'(r_t2);
                    n_var    = (vsum > 66'(admee_pkg::COUNT_MAX)) ? admee_pkg::COUNT_MAX
                                                                  : vsum[31:0];
                    mv_we    = 1'b1;
                    mv_wdata = {r_mnew, n_var};
                    n_state  = admee_pkg::S_BL;
                end
            end
            admee_pkg::S_BL: begin
                // A negative prior counts as zero.
                pclamp  = r_prior[31] ? 33'd0 : {1'b0, r_prior};
                diff    = pclamp - {1'b0, r_var};
                mag     = diff[32] ? (~diff + 33'd1) : diff;
                bprod   = mag * r_pw;
                n_neg   = diff[32];
                n_prod  = 65'(bprod);
                if (bden == '0) begin
                    n_mass  = r_var;
                    n_state = admee_pkg::S_INV;
                end else begin
                    n_state = admee_pkg::S_BLG;
                end
            end
            admee_pkg::S_BLG: begin
                div_num   = r_prod + 65'(bden >> 1);
                div_den   = 48'(bden);
                div_start = 1'b1;
                n_state   = admee_pkg::S_BLW;
            end
            admee_pkg::S_BLW: begin
                if (div_done) begin
                    n_mass  = r_neg ? (r_var - div_quot[31:0]) : (r_var + div_quot[31:0]);
                    n_state = admee_pkg::S_INV;
                end
            end
            admee_pkg::S_INV: begin
                if (r_mass == '0) begin
                    // Zero mass saturates the inverse root.
                    n_inv   = admee_pkg::COUNT_MAX;
                    n_state = admee_pkg::S_EMIT;
                end else begin
                    div_num   = 65'd1 << 48;
                    div_den   = 48'(r_mass);
                    div_start = 1'b1;
                    n_state   = admee_pkg::S_INVW;
                end
            end
            admee_pkg::S_INVW: begin
                if (div_done) begin
                    sq_start = 1'b1;
                    n_state  = admee_pkg::S_SQW;
                end
            end
            admee_pkg::S_SQW: begin
                if (sq_done) begin
                    n_inv   = sq_root[31:0];
                    n_state = admee_pkg::S_EMIT;
                end
            end
            admee_pkg::S_EMIT: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid = 1'b1;
                    n_oidx   = r_idx;
                    n_omass  = r_mass;
                    n_oinv   = r_inv;
                    // The count advances only once the whole item is done.
                    if (r_op == admee_pkg::OP_ADD && r_last &&
                        r_count != admee_pkg::COUNT_MAX) begin
                        n_count = cnt1[31:0];
                    end
                    n_state = admee_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = admee_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= admee_pkg::S_CLEAR;
            r_clr    <= '0;
            r_count  <= '0;
            r_pw     <= admee_pkg::DEFAULT_WEIGHT;
            r_freeze <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_count  <= n_count;
            r_pw     <= n_pw;
            r_freeze <= n_freeze;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;  r_idx <= n_idx;  r_x <= n_x;  r_last <= n_last;
        r_mean <= n_mean;  r_var <= n_var;  r_prior <= n_prior;  r_mnew <= n_mnew;
        r_neg <= n_neg;  r_c <= n_c;  r_mass <= n_mass;  r_inv <= n_inv;
        r_prod <= n_prod;  r_t2 <= n_t2;
        r_oidx <= n_oidx;  r_omass <= n_omass;  r_oinv <= n_oinv;
    end

    // A clear item empties the count and starts the zeroing pass.
    a_clear_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in.opcode == admee_pkg::OP_CLEAR |=>
            r_count == '0 && r_state == admee_pkg::S_CLEAR)
        else $error("clear did not start the zeroing pass");

    // The shared divider is never restarted while it is still working.
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // The count only changes through a clear or at the end of an add.
    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != admee_pkg::S_EMIT && !in_acc |=> $stable(r_count))
        else $error("sample count changed mid-item");

    // A pending result is never overwritten before it has been taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !o_out.ready |=> r_ovalid && $stable(r_omass) && $stable(r_oidx))
        else $error("pending result lost");
endmodule
`default_nettype wire

// File: rtl/admee_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module admee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: rtl/admee_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module admee_div (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic [admee_pkg::DIV_NUM_W-1:0]     i_num,
    input  wire logic [admee_pkg::DIV_DEN_W-1:0]     i_den,
    output logic                                     o_busy,
    output logic                                     o_done,
    output logic      [admee_pkg::DIV_NUM_W-1:0]     o_quot
);
    logic [admee_pkg::DIV_DEN_W-1:0] r_rem, r_den;
    logic [admee_pkg::DIV_NUM_W-1:0] r_quo;
    logic [admee_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                            r_busy, r_done;
    logic [admee_pkg::DIV_DEN_W:0]   rem_sh, rem_sub;
    logic                            ge;

    assign rem_sh  = {r_rem, r_quo[admee_pkg::DIV_NUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign ge      = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == admee_pkg::DIV_CNT_W'(admee_pkg::DIV_NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[admee_pkg::DIV_DEN_W-1:0] : rem_sh[admee_pkg::DIV_DEN_W-1:0];
            r_quo <= {r_quo[admee_pkg::DIV_NUM_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quo;
endmodule
`default_nettype wire

// File: rtl/admee_sqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
`default_nettype none
module admee_sqrt (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [admee_pkg::SQRT_W-1:0]   i_val,
    output logic                                o_done,
    output logic      [admee_pkg::SQRT_W-1:0]   o_root
);
    logic [admee_pkg::SQRT_W-1:0] r_v, r_r, r_bit, trial;
    logic                         r_busy, r_done, take;

    assign trial = r_r + r_bit;
    assign take  = r_v >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_val;
            r_r   <= '0;
            r_bit <= {1'b1, {(admee_pkg::SQRT_W-1){1'b0}}};
        end else if (r_busy) begin
            if (take) begin
                r_v <= r_v - trial;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r;
endmodule
`default_nettype wire
